>>> sv/bssc_pkg.sv
// Shared types, constants and tables for the six-step commutator.
// No dependencies; imported by every other file of the block.
package bssc_pkg;

   // Encoder and drive geometry
   localparam int ENC_RES       = 1536;
   localparam int STEP60        = 256;
   localparam int DUTY_MAX      = 1023;
   localparam int DUTY_SCALE    = 100;
   localparam int ADVANCE_RESET = -15;
   localparam int NUM_STEPS     = 6;
   localparam int PERIOD_LIMIT_RESET = 80000;

   // Field widths
   localparam int FUNC_W  = 3;
   localparam int MODE_W  = 2;
   localparam int TIMER_W = 24;
   localparam int ADV_W   = 8;
   localparam int PCT_W   = 7;
   localparam int SW_W    = 3;
   localparam int DUTY_W  = 10;
   localparam int STEP_W  = 3;
   localparam int POS_W   = 11;
   localparam int REV_W   = 32;
   localparam int SHIFT_W = 9;
   localparam int SUM_W   = 13;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_FWD_EDGE  = 3'd0,
      FUNC_BACK_EDGE = 3'd1,
      FUNC_TICK      = 3'd2,
      FUNC_MODE      = 3'd3,
      FUNC_ADVANCE   = 3'd4,
      FUNC_DUTY      = 3'd5
   } func_type;

   typedef enum logic [MODE_W-1:0] {
      MODE_FORWARD = 2'd0,
      MODE_REVERSE = 2'd1,
      MODE_BRAKE   = 2'd2
   } mode_type;

   typedef struct packed {
      func_type                  func;
      logic [TIMER_W-1:0]        timer_value;
      mode_type                  mode;
      logic signed [ADV_W-1:0]   advance;
      logic [PCT_W-1:0]          duty_percent;
   } req_item_type;

   typedef struct packed {
      logic [SW_W-1:0]           high_side;
      logic [SW_W-1:0]           low_side;
      logic [DUTY_W-1:0]         duty_out;
      logic [STEP_W-1:0]         sector;
      logic [POS_W-1:0]          fwd_position;
      logic [POS_W-1:0]          back_position;
      logic [TIMER_W-1:0]        period_out;
      logic signed [REV_W-1:0]   revolutions_out;
   } rsp_item_type;

   // Bridge patterns per sector, bit0 phase A
   typedef logic [SW_W-1:0] switch_tab_type [NUM_STEPS];
   localparam switch_tab_type HIGH_TAB = '{3'b001, 3'b010, 3'b010, 3'b100, 3'b100, 3'b001};
   localparam switch_tab_type LOW_TAB  = '{3'b100, 3'b100, 3'b001, 3'b001, 3'b010, 3'b010};

   // Percent to duty counts, saturating above full scale
   typedef logic [DUTY_W-1:0] duty_tab_type [2**PCT_W];

   function automatic duty_tab_type build_duty_tab();
      duty_tab_type tab;
      int           pct;
      for (int i = 0; i < 2**PCT_W; i++) begin
         pct    = (i > DUTY_SCALE) ? DUTY_SCALE : i;
         tab[i] = DUTY_W'((pct * DUTY_MAX) / DUTY_SCALE);
      end
      return tab;
   endfunction

   localparam duty_tab_type DUTY_TAB = build_duty_tab();

   // Reset values of the stored state
   localparam logic signed [ADV_W-1:0] ADVANCE_RESET_VAL = ADV_W'(ADVANCE_RESET);
   localparam logic [POS_W-1:0] FWD_POS_RESET  = POS_W'(STEP60 - ADVANCE_RESET);
   localparam logic [POS_W-1:0] BACK_POS_RESET = POS_W'(ENC_RES + ADVANCE_RESET);
   localparam logic [TIMER_W-1:0] LIMIT_RESET_VAL = TIMER_W'(PERIOD_LIMIT_RESET);

   localparam logic signed [SUM_W-1:0] ENC_RES_S = SUM_W'(ENC_RES);
   localparam logic signed [SUM_W-1:0] STEP60_S  = SUM_W'(STEP60);
   localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(NUM_STEPS - 1);
   localparam logic [STEP_W-1:0] HALF_TURN = STEP_W'(NUM_STEPS / 2);

endpackage

>>> sv/bssc_req_if.sv
// Request channel: valid/ready handshake with the command payload.
// Depends on bssc_pkg for field widths.
interface bssc_req_if import bssc_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic [FUNC_W-1:0]       func;
   logic [TIMER_W-1:0]      timer_value;
   logic [MODE_W-1:0]       mode;
   logic signed [ADV_W-1:0] advance;
   logic [PCT_W-1:0]        duty_percent;

   modport source (output valid, func, timer_value, mode, advance, duty_percent,
                   input ready);
   modport sink   (input valid, func, timer_value, mode, advance, duty_percent,
                   output ready);
endinterface

>>> sv/bssc_rsp_if.sv
// Response channel: valid/ready handshake with the bridge and status payload.
// Depends on bssc_pkg for field widths.
interface bssc_rsp_if import bssc_pkg::*;;
   logic                    valid;
   logic                    ready;
   logic [SW_W-1:0]         high_side;
   logic [SW_W-1:0]         low_side;
   logic [DUTY_W-1:0]       duty_out;
   logic [STEP_W-1:0]       sector;
   logic [POS_W-1:0]        fwd_position;
   logic [POS_W-1:0]        back_position;
   logic [TIMER_W-1:0]      period_out;
   logic signed [REV_W-1:0] revolutions_out;

   modport source (output valid, high_side, low_side, duty_out, sector, fwd_position,
                   back_position, period_out, revolutions_out, input ready);
   modport sink   (input valid, high_side, low_side, duty_out, sector, fwd_position,
                   back_position, period_out, revolutions_out, output ready);
endinterface

>>> sv/bssc_in_stage.sv
// Input register: captures one request and holds it until the core takes it.
// Depends on bssc_pkg and bssc_req_if.
module bssc_in_stage import bssc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   bssc_req_if.sink     req_chan,
   input  logic         take,
   output logic         item_valid,
   output req_item_type item
);

   logic         valid_ff, valid_in;
   req_item_type item_ff;
   logic         accept;

   // Free when empty or when the held request moves on this cycle
   assign req_chan.ready = !valid_ff || take;
   assign accept         = req_chan.valid && req_chan.ready;

   always_comb begin
      valid_in = accept || (valid_ff && !take);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload, no reset needed
   always_ff @(posedge clock) begin
      if (accept) begin
         item_ff.func         <= func_type'(req_chan.func);
         item_ff.timer_value  <= req_chan.timer_value;
         item_ff.mode         <= mode_type'(req_chan.mode);
         item_ff.advance      <= req_chan.advance;
         item_ff.duty_percent <= req_chan.duty_percent;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

>>> sv/bssc_core.sv
// Commutator state and its single-pass update for one request.
// Depends on bssc_pkg.
module bssc_core import bssc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_en,
   input  logic [TIMER_W-1:0] csr_write_data,
   input  logic               take,
   input  req_item_type       item,
   output rsp_item_type       result
);

   logic [TIMER_W-1:0]        limit_ff;
   logic [TIMER_W-1:0]        prev_timer_ff, prev_timer_in;
   logic [TIMER_W-1:0]        period_ff, period_in;
   logic [STEP_W-1:0]         step_ff, step_in;
   logic [REV_W-1:0]          rev_ff, rev_in;
   logic signed [SHIFT_W-1:0] shift_ff, shift_in;
   logic signed [ADV_W-1:0]   adv_now_ff, adv_now_in;
   logic                      braking_ff, braking_in;
   logic                      reverse_ff, reverse_in;
   logic [DUTY_W-1:0]         duty_ff, duty_in;
   logic [POS_W-1:0]          fwd_pos_ff, fwd_pos_in;
   logic [POS_W-1:0]          back_pos_ff, back_pos_in;

   logic [TIMER_W:0]          period_meas;
   logic [STEP_W-1:0]         step_up, step_down, step_flip;
   logic signed [SUM_W-1:0]   move_fwd, move_back;
   logic                      wants_rev;

   // Add a move to a position and fold back into the encoder range
   function automatic logic [POS_W-1:0] wrap_pos(logic [POS_W-1:0] pos,
                                                 logic signed [SUM_W-1:0] mv);
      logic signed [SUM_W-1:0] sum;
      sum = $signed({{(SUM_W-POS_W){1'b0}}, pos}) + mv;
      if (sum < 0) begin
         sum = sum + ENC_RES_S;
      end else if (sum >= ENC_RES_S) begin
         sum = sum - ENC_RES_S;
      end
      return sum[POS_W-1:0];
   endfunction

   // Down-counter period, wrapping through 2^24 when the sample is not below
   assign period_meas = {(item.timer_value >= prev_timer_ff), prev_timer_ff}
                      - {1'b0, item.timer_value};

   // Sector neighbors
   assign step_up   = (step_ff >= LAST_STEP) ? '0 : step_ff + 1'b1;
   assign step_down = (step_ff == '0) ? LAST_STEP : step_ff - 1'b1;
   assign step_flip = (step_ff >= HALF_TURN) ? step_ff - HALF_TURN : step_ff + HALF_TURN;

   // Sixty-degree move plus the pending advance change
   assign move_fwd  = STEP60_S + SUM_W'(shift_ff);
   assign move_back = SUM_W'(shift_ff) - STEP60_S;
   assign wants_rev = (item.mode == MODE_REVERSE);

   // Next state
   always_comb begin
      prev_timer_in = prev_timer_ff;
      period_in     = period_ff;
      step_in       = step_ff;
      rev_in        = rev_ff;
      shift_in      = shift_ff;
      adv_now_in    = adv_now_ff;
      braking_in    = braking_ff;
      reverse_in    = reverse_ff;
      duty_in       = duty_ff;
      fwd_pos_in    = fwd_pos_ff;
      back_pos_in   = back_pos_ff;
      unique case (item.func) inside
         FUNC_FWD_EDGE, FUNC_BACK_EDGE: begin
            prev_timer_in = item.timer_value;
            if (period_meas < {1'b0, limit_ff}) begin
               period_in = period_meas[TIMER_W-1:0];
            end
            shift_in = '0;
            if (item.func == FUNC_FWD_EDGE) begin
               step_in     = step_up;
               rev_in      = (step_ff >= LAST_STEP) ? rev_ff + 1'b1 : rev_ff;
               fwd_pos_in  = wrap_pos(fwd_pos_ff, move_fwd);
               back_pos_in = wrap_pos(back_pos_ff, move_fwd);
            end else begin
               step_in     = step_down;
               rev_in      = (step_ff == '0) ? rev_ff - 1'b1 : rev_ff;
               fwd_pos_in  = wrap_pos(fwd_pos_ff, move_back);
               back_pos_in = wrap_pos(back_pos_ff, move_back);
            end
         end
         FUNC_TICK: begin
            step_in = step_up;
         end
         FUNC_MODE: begin
            case (item.mode) inside
               MODE_BRAKE: begin
                  braking_in = 1'b1;
               end
               MODE_FORWARD, MODE_REVERSE: begin
                  braking_in = 1'b0;
                  if (reverse_ff != wants_rev) begin
                     reverse_in = wants_rev;
                     step_in    = step_flip;
                  end
               end
               default: begin
               end
            endcase
         end
         FUNC_ADVANCE: begin
            shift_in   = SHIFT_W'(adv_now_ff) - SHIFT_W'(item.advance);
            adv_now_in = item.advance;
         end
         FUNC_DUTY: begin
            duty_in = DUTY_TAB[item.duty_percent];
         end
         default: begin
         end
      endcase
   end

   // State registers, written when a request passes through
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_timer_ff <= '0;
         period_ff     <= '0;
         step_ff       <= '0;
         rev_ff        <= '0;
         shift_ff      <= '0;
         adv_now_ff    <= ADVANCE_RESET_VAL;
         braking_ff    <= 1'b0;
         reverse_ff    <= 1'b0;
         duty_ff       <= '0;
         fwd_pos_ff    <= FWD_POS_RESET;
         back_pos_ff   <= BACK_POS_RESET;
      end else if (take) begin
         prev_timer_ff <= prev_timer_in;
         period_ff     <= period_in;
         step_ff       <= step_in;
         rev_ff        <= rev_in;
         shift_ff      <= shift_in;
         adv_now_ff    <= adv_now_in;
         braking_ff    <= braking_in;
         reverse_ff    <= reverse_in;
         duty_ff       <= duty_in;
         fwd_pos_ff    <= fwd_pos_in;
         back_pos_ff   <= back_pos_in;
      end
   end

   // Stall limit register
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= LIMIT_RESET_VAL;
      end else if (csr_write_en) begin
         limit_ff <= csr_write_data;
      end
   end

   // Response reflects the state after this request
   always_comb begin
      result.high_side       = braking_in ? '1 : HIGH_TAB[step_in];
      result.low_side        = braking_in ? '0 : LOW_TAB[step_in];
      result.duty_out        = duty_in;
      result.sector          = step_in;
      result.fwd_position    = fwd_pos_in;
      result.back_position   = back_pos_in;
      result.period_out      = period_in;
      result.revolutions_out = $signed(rev_in);
   end

endmodule

>>> sv/bssc_out_stage.sv
// Output register: holds one response until the sink takes it.
// Depends on bssc_pkg and bssc_rsp_if.
module bssc_out_stage import bssc_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         load,
   input  rsp_item_type data,
   output logic         room,
   bssc_rsp_if.source   rsp_chan
);

   logic         valid_ff, valid_in;
   rsp_item_type data_ff;

   // Free when empty or when the held response leaves this cycle
   assign room = !valid_ff || rsp_chan.ready;

   always_comb begin
      valid_in = load || (valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= data;
      end
   end

   assign rsp_chan.valid           = valid_ff;
   assign rsp_chan.high_side       = data_ff.high_side;
   assign rsp_chan.low_side        = data_ff.low_side;
   assign rsp_chan.duty_out        = data_ff.duty_out;
   assign rsp_chan.sector          = data_ff.sector;
   assign rsp_chan.fwd_position    = data_ff.fwd_position;
   assign rsp_chan.back_position   = data_ff.back_position;
   assign rsp_chan.period_out      = data_ff.period_out;
   assign rsp_chan.revolutions_out = data_ff.revolutions_out;

endmodule

>>> sv/bldc_six_step_commutator.sv
// Six-step brushless commutator, top level.
// Path: an accepted request is held in the input register, and its response in the result register.
// Throughput: one request per cycle without back-pressure; the state update is a single pass of adds and lookups.
// A stalled response holds the input register, so requests wait only under back-pressure.
// Reset: synchronous; sector 0, forward, not braking, duty 0, stall limit 80000.
// Depends on bssc_pkg, bssc_req_if, bssc_rsp_if, bssc_in_stage, bssc_core, bssc_out_stage.
module bldc_six_step_commutator import bssc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_en,
   input  logic [TIMER_W-1:0] csr_write_data,
   bssc_req_if.sink           req_chan,
   bssc_rsp_if.source         rsp_chan
);

   logic         item_valid;
   req_item_type item;
   rsp_item_type result;
   logic         room;
   logic         take;

   // A held request moves into the state when the response slot is free
   assign take = item_valid && room;

   bssc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   bssc_core u_core (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .take           (take),
      .item           (item),
      .result         (result)
   );

   bssc_out_stage u_out_stage (
      .clock    (clock),
      .reset    (reset),
      .load     (take),
      .data     (result),
      .room     (room),
      .rsp_chan (rsp_chan)
   );

endmodule

>>> tb/bssc_checker.sv
// Scoreboard for the six-step commutator: watches the request, response and csr ports.
// Keeps its own copy of the commutation state and reports mismatches to the testbench top.
// Depends on bssc_pkg, bssc_req_if and bssc_rsp_if.
module bssc_checker import bssc_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_en,
   input  logic [TIMER_W-1:0] csr_write_data,
   bssc_req_if                req_mon,
   bssc_rsp_if                rsp_mon,
   output int                 mismatch_count,
   output int                 results_owed
);

   // Drive geometry, kept apart from the design's own constants
   localparam int ENC_COUNTS  = 1536;
   localparam int SIXTY_DEG   = 256;
   localparam int FULL_DUTY   = 1023;
   localparam int PCT_FULL    = 100;
   localparam int ADV_AT_RST  = -15;
   localparam int STALL_AT_RST = 80000;
   localparam int SECTORS     = 6;
   localparam int REPORT_MAX  = 10;
   localparam logic [SW_W-1:0] ALL_ON  = 3'b111;
   localparam logic [SW_W-1:0] ALL_OFF = 3'b000;

   typedef logic [SW_W-1:0] pattern_tab_type [SECTORS];
   localparam pattern_tab_type HIGH_PATTERN = '{3'b001, 3'b010, 3'b010, 3'b100, 3'b100, 3'b001};
   localparam pattern_tab_type LOW_PATTERN  = '{3'b100, 3'b100, 3'b001, 3'b001, 3'b010, 3'b010};

   // Commutation state
   logic [TIMER_W-1:0] stall_limit;
   logic [TIMER_W-1:0] last_sample;
   logic [TIMER_W-1:0] period_q;
   logic [STEP_W-1:0]  sector_q;
   logic [REV_W-1:0]   turns_q;
   int                 shift_q;
   int                 advance_q;
   bit                 brake_q;
   bit                 reverse_q;
   logic [DUTY_W-1:0]  duty_q;
   int                 fwd_q;
   int                 back_q;

   rsp_item_type bridge_expect_q[$];

   function automatic int wrap_encoder(int x);
      int r;
      r = x % ENC_COUNTS;
      if (r < 0) begin
         r += ENC_COUNTS;
      end
      return r;
   endfunction

   function automatic void restore_power_on();
      stall_limit = TIMER_W'(STALL_AT_RST);
      last_sample = '0;
      period_q    = '0;
      sector_q    = '0;
      turns_q     = '0;
      shift_q     = 0;
      advance_q   = ADV_AT_RST;
      brake_q     = 1'b0;
      reverse_q   = 1'b0;
      duty_q      = '0;
      fwd_q       = wrap_encoder(SIXTY_DEG - ADV_AT_RST);
      back_q      = wrap_encoder(ENC_COUNTS + ADV_AT_RST);
   endfunction

   // Rotor edge: measure the period on the down-counter, step sector and positions
   function automatic void rotor_edge(logic [TIMER_W-1:0] sample, bit forward);
      logic [TIMER_W:0] span;
      int               move;
      if (sample >= last_sample) begin
         span = {1'b0, last_sample} + (25'd1 << TIMER_W) - {1'b0, sample};
      end else begin
         span = {1'b0, last_sample} - {1'b0, sample};
      end
      last_sample = sample;
      if (span < {1'b0, stall_limit}) begin
         period_q = span[TIMER_W-1:0];
      end
      if (forward) begin
         if (sector_q == STEP_W'(SECTORS - 1)) begin
            sector_q = '0;
            turns_q  = turns_q + 1;
         end else begin
            sector_q = sector_q + 1'b1;
         end
         move = SIXTY_DEG;
      end else begin
         if (sector_q == '0) begin
            sector_q = STEP_W'(SECTORS - 1);
            turns_q  = turns_q - 1;
         end else begin
            sector_q = sector_q - 1'b1;
         end
         move = -SIXTY_DEG;
      end
      move    = move + shift_q;
      shift_q = 0;
      fwd_q   = wrap_encoder(fwd_q + move);
      back_q  = wrap_encoder(back_q + move);
   endfunction

   // Apply one request and return the bridge status it should produce
   function automatic rsp_item_type apply_command(logic [FUNC_W-1:0] func,
                                                   logic [TIMER_W-1:0] sample,
                                                   logic [MODE_W-1:0] mode,
                                                   logic signed [ADV_W-1:0] adv,
                                                   logic [PCT_W-1:0] pct);
      rsp_item_type status;
      int           pct_sat;
      bit           want_reverse;
      case (func)
         FUNC_FWD_EDGE: begin
            rotor_edge(sample, 1'b1);
         end
         FUNC_BACK_EDGE: begin
            rotor_edge(sample, 1'b0);
         end
         FUNC_TICK: begin
            sector_q = (sector_q == STEP_W'(SECTORS - 1)) ? '0 : sector_q + 1'b1;
         end
         FUNC_MODE: begin
            case (mode) inside
               MODE_BRAKE: begin
                  brake_q = 1'b1;
               end
               MODE_FORWARD, MODE_REVERSE: begin
                  brake_q      = 1'b0;
                  want_reverse = (mode == MODE_REVERSE);
                  if (want_reverse != reverse_q) begin
                     reverse_q = want_reverse;
                     sector_q  = STEP_W'((int'(sector_q) + SECTORS / 2) % SECTORS);
                  end
               end
               default: ;
            endcase
         end
         FUNC_ADVANCE: begin
            // a new advance replaces whatever shift is still pending
            shift_q   = advance_q - int'(adv);
            advance_q = int'(adv);
         end
         FUNC_DUTY: begin
            pct_sat = (int'(pct) > PCT_FULL) ? PCT_FULL : int'(pct);
            duty_q  = DUTY_W'((pct_sat * FULL_DUTY) / PCT_FULL);
         end
         default: ;
      endcase
      status.high_side       = brake_q ? ALL_ON : HIGH_PATTERN[sector_q];
      status.low_side        = brake_q ? ALL_OFF : LOW_PATTERN[sector_q];
      status.duty_out        = duty_q;
      status.sector          = sector_q;
      status.fwd_position    = POS_W'(fwd_q);
      status.back_position   = POS_W'(back_q);
      status.period_out      = period_q;
      status.revolutions_out = turns_q;
      return status;
   endfunction

   function automatic string show_status(rsp_item_type s);
      return $sformatf("hs=%0h ls=%0h duty=%0d sector=%0d fwd=%0d back=%0d period=%0d revs=%0d",
                       s.high_side, s.low_side, s.duty_out, s.sector, s.fwd_position,
                       s.back_position, s.period_out, s.revolutions_out);
   endfunction

   function automatic void note_failure(string why);
      mismatch_count++;
      if (mismatch_count <= REPORT_MAX) begin
         $display("%0t: %s", $realtime, why);
      end
   endfunction

   // Compare one accepted response against the oldest prediction
   function automatic void check_status();
      rsp_item_type got;
      rsp_item_type want;
      got.high_side       = rsp_mon.high_side;
      got.low_side        = rsp_mon.low_side;
      got.duty_out        = rsp_mon.duty_out;
      got.sector          = rsp_mon.sector;
      got.fwd_position    = rsp_mon.fwd_position;
      got.back_position   = rsp_mon.back_position;
      got.period_out      = rsp_mon.period_out;
      got.revolutions_out = rsp_mon.revolutions_out;
      if (bridge_expect_q.size() == 0) begin
         note_failure({"response with no request pending: ", show_status(got)});
      end else begin
         want = bridge_expect_q.pop_front();
         if (got.high_side !== want.high_side || got.low_side !== want.low_side ||
             got.duty_out !== want.duty_out || got.sector !== want.sector ||
             got.fwd_position !== want.fwd_position ||
             got.back_position !== want.back_position ||
             got.period_out !== want.period_out ||
             got.revolutions_out !== want.revolutions_out) begin
            note_failure({"mismatch\n  expected ", show_status(want),
                          "\n  actual   ", show_status(got)});
         end
      end
   endfunction

   // Sample every port at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         restore_power_on();
         bridge_expect_q.delete();
         mismatch_count = 0;
      end else begin
         if (csr_write_en) begin
            stall_limit = csr_write_data;
         end
         if (rsp_mon.valid === 1'b1 && rsp_mon.ready === 1'b1) begin
            check_status();
         end
         if (req_mon.valid === 1'b1 && req_mon.ready === 1'b1) begin
            bridge_expect_q.push_back(apply_command(req_mon.func, req_mon.timer_value,
                                                    req_mon.mode, req_mon.advance,
                                                    req_mon.duty_percent));
         end
      end
      results_owed = bridge_expect_q.size();
   end

endmodule

>>> tb/tb_bldc_six_step_commutator.sv
// Testbench top for the six-step commutator: clock, reset, request and csr stimulus.
// Checking is done by bssc_checker; depends on bssc_pkg and the two channel interfaces.
module tb_bldc_six_step_commutator;
   import bssc_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_SPARE_A = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_B = 3'd7;
   localparam logic [MODE_W-1:0] MODE_SPARE   = 2'd3;
   localparam int                DEFAULT_LIMIT = 80000;
   localparam int                MAX_LIMIT     = 24'hFFFFFF;
   localparam int                DRAIN_CYCLES  = 4;
   localparam int                TAIL_CYCLES   = 10;

   logic               clock;
   logic               reset;
   logic               csr_write_en;
   logic [TIMER_W-1:0] csr_write_data;

   bssc_req_if req_chan();
   bssc_rsp_if rsp_chan();

   int                 mismatch_total;
   int                 results_owed;
   int                 send_idle_pct;
   int                 recv_stall_pct;
   int                 limit_now;
   logic [TIMER_W-1:0] rotor_timer;

   bldc_six_step_commutator i_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_chan       (req_chan),
      .rsp_chan       (rsp_chan)
   );

   bssc_checker i_checker (
      .clock          (clock),
      .reset          (reset),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .req_mon        (req_chan),
      .rsp_mon        (rsp_chan),
      .mismatch_count (mismatch_total),
      .results_owed   (results_owed)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Hard stop if the block hangs
   initial begin
      #5000000;
      $display("TB_ERROR");
      $finish;
   end

   // Response side back-pressure
   initial begin
      rsp_chan.ready = 1'b0;
      forever begin
         @(negedge clock);
         rsp_chan.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // One request; entered and left at a falling edge, valid stays up on return
   task automatic send_request(logic [FUNC_W-1:0] func, logic [TIMER_W-1:0] sample,
                               logic [MODE_W-1:0] mode, logic signed [ADV_W-1:0] adv,
                               logic [PCT_W-1:0] pct);
      while ($urandom_range(99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid        <= 1'b1;
      req_chan.func         <= func;
      req_chan.timer_value  <= sample;
      req_chan.mode         <= mode;
      req_chan.advance      <= adv;
      req_chan.duty_percent <= pct;
      @(posedge clock);
      while (req_chan.ready !== 1'b1) begin
         @(posedge clock);
      end
      @(negedge clock);
   endtask

   // Edges are mostly plausible down-counter steps; the rest are stalls and junk
   task automatic random_request();
      logic [FUNC_W-1:0]  func;
      logic [TIMER_W-1:0] sample;
      int                 pick;
      int                 cap;
      pick   = $urandom_range(99);
      sample = TIMER_W'($urandom);
      if (pick < 42) begin
         func = FUNC_FWD_EDGE;
      end else if (pick < 62) begin
         func = FUNC_BACK_EDGE;
      end else if (pick < 70) begin
         func = FUNC_TICK;
      end else if (pick < 79) begin
         func = FUNC_MODE;
      end else if (pick < 87) begin
         func = FUNC_ADVANCE;
      end else if (pick < 95) begin
         func = FUNC_DUTY;
      end else begin
         func = $urandom_range(1) ? FUNC_SPARE_A : FUNC_SPARE_B;
      end
      if (func == FUNC_FWD_EDGE || func == FUNC_BACK_EDGE) begin
         pick = $urandom_range(99);
         cap  = (limit_now > 400001) ? 400000 : ((limit_now > 2) ? limit_now - 1 : 1);
         if (pick < 75) begin
            sample = rotor_timer - TIMER_W'($urandom_range(cap, 1));
         end else if (pick < 90) begin
            sample = rotor_timer - TIMER_W'(limit_now + $urandom_range(20000));
         end else if (pick < 94) begin
            sample = rotor_timer;
         end
         rotor_timer = sample;
      end
      send_request(func, sample, MODE_W'($urandom_range(3)), ADV_W'($urandom),
                   PCT_W'($urandom_range(127)));
   endtask

   // Let everything drain, then change the stall limit and the idle mix
   task automatic start_phase(int limit, int s_idle, int r_stall);
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (results_owed != 0) begin
         @(negedge clock);
      end
      repeat (DRAIN_CYCLES) @(negedge clock);
      csr_write_en   <= 1'b1;
      csr_write_data <= TIMER_W'(limit);
      @(negedge clock);
      csr_write_en   <= 1'b0;
      limit_now      = limit;
      send_idle_pct  = s_idle;
      recv_stall_pct = r_stall;
   endtask

   initial begin
      reset                 = 1'b1;
      csr_write_en          = 1'b0;
      csr_write_data        = '0;
      req_chan.valid        = 1'b0;
      req_chan.func         = FUNC_TICK;
      req_chan.timer_value  = '0;
      req_chan.mode         = MODE_FORWARD;
      req_chan.advance      = '0;
      req_chan.duty_percent = '0;
      send_idle_pct         = 7;
      recv_stall_pct        = 74;
      limit_now             = DEFAULT_LIMIT;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: edge timing corners, sector wraps, settings and unused codes
      send_request(FUNC_TICK, 24'h000000, MODE_FORWARD, 8'sd0, 7'd0);
      send_request(FUNC_FWD_EDGE, 24'h000000, MODE_FORWARD, 8'sd0, 7'd0);  // equal: stall
      send_request(FUNC_FWD_EDGE, 24'hFFFFFF, MODE_FORWARD, 8'sd0, 7'd0);  // wraps, period 1
      send_request(FUNC_FWD_EDGE, 24'hFFFC17, MODE_FORWARD, 8'sd0, 7'd0);
      send_request(FUNC_BACK_EDGE, 24'hFFFC17, MODE_FORWARD, 8'sd0, 7'd0);
      send_request(FUNC_BACK_EDGE, 24'hFE0000, MODE_FORWARD, 8'sd0, 7'd0); // above limit
      send_request(FUNC_BACK_EDGE, 24'hFCC780, MODE_FORWARD, 8'sd0, 7'd0); // exactly limit
      send_request(FUNC_BACK_EDGE, 24'hFB8F01, MODE_FORWARD, 8'sd0, 7'd0); // one below
      send_request(FUNC_BACK_EDGE, 24'hFB8000, MODE_FORWARD, 8'sd0, 7'd0); // sector 0 -> 5
      send_request(FUNC_BACK_EDGE, 24'hFB7000, MODE_FORWARD, 8'sd0, 7'd0);
      send_request(FUNC_ADVANCE, 24'hFFFFFF, MODE_BRAKE, 8'sd127, 7'd127);
      send_request(FUNC_FWD_EDGE, 24'hFB6000, MODE_FORWARD, 8'sd0, 7'd0);
      send_request(FUNC_ADVANCE, 24'h000000, MODE_FORWARD, -8'sd128, 7'd0);
      send_request(FUNC_ADVANCE, 24'h000000, MODE_FORWARD, 8'sd0, 7'd0);   // replaces shift
      send_request(FUNC_FWD_EDGE, 24'hFB5000, MODE_FORWARD, 8'sd0, 7'd0);  // sector 5 -> 0
      send_request(FUNC_DUTY, 24'h000000, MODE_FORWARD, 8'sd0, 7'd100);
      send_request(FUNC_DUTY, 24'h000000, MODE_FORWARD, 8'sd0, 7'd127);    // saturates
      send_request(FUNC_DUTY, 24'h000000, MODE_FORWARD, 8'sd0, 7'd0);
      send_request(FUNC_DUTY, 24'h000000, MODE_FORWARD, 8'sd0, 7'd33);
      send_request(FUNC_MODE, 24'h000000, MODE_BRAKE, 8'sd0, 7'd0);
      send_request(FUNC_TICK, 24'h000000, MODE_FORWARD, 8'sd0, 7'd0);
      send_request(FUNC_MODE, 24'h000000, MODE_SPARE, 8'sd0, 7'd0);        // ignored
      send_request(FUNC_MODE, 24'h000000, MODE_REVERSE, 8'sd0, 7'd0);
      send_request(FUNC_MODE, 24'h000000, MODE_REVERSE, 8'sd0, 7'd0);      // no change
      send_request(FUNC_MODE, 24'h000000, MODE_FORWARD, 8'sd0, 7'd0);
      send_request(FUNC_SPARE_A, 24'hFFFFFF, MODE_SPARE, -8'sd1, 7'd127);
      send_request(FUNC_SPARE_B, 24'hFFFFFF, MODE_SPARE, -8'sd1, 7'd127);
      rotor_timer = 24'hFB5000;

      // Random phases across stall limits and idle mixes
      start_phase(MAX_LIMIT, 7, 74);
      repeat (400) random_request();
      start_phase(1, 74, 7);
      repeat (300) random_request();
      start_phase($urandom_range(150000, 2000), 0, 0);
      repeat (400) random_request();
      start_phase(DEFAULT_LIMIT, 0, 0);
      repeat (325) random_request();

      // Drain and give the verdict
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (results_owed != 0) begin
         @(negedge clock);
      end
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_total == 0 && results_owed == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule
